// ===== sv/teq_pkg.sv =====
package teq_pkg;

    // request kinds carried in tuser
    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // result status codes carried in tuser
    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EXPIRED   = 3'd4;
    localparam logic [2:0] ST_NONE_DUE  = 3'd5;

    // stream word widths
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_USER_W = 3;
    localparam int TGT_W      = 4;
    localparam int FIELD_W    = 32;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;
        logic del;
        logic pop;
    } t_cell_cmd;

endpackage

// ===== sv/teq_cell.sv =====
module teq_cell #(
    parameter int TIME_BITS = 32,
    parameter int HANDLE_W  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  teq_pkg::t_cell_cmd    i_cmd,
    input  logic [TIME_BITS-1:0]  i_key,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic [teq_pkg::TGT_W-1:0] i_tgt,
    input  logic [HANDLE_W-1:0]   i_new_handle,
    input  logic                  i_left_valid,
    input  logic [TIME_BITS-1:0]  i_left_exp,
    input  logic [HANDLE_W-1:0]   i_left_handle,
    input  logic                  i_left_le,
    input  logic                  i_right_valid,
    input  logic [TIME_BITS-1:0]  i_right_exp,
    input  logic [HANDLE_W-1:0]   i_right_handle,
    input  logic                  i_hit_in,
    output logic                  o_valid,
    output logic [TIME_BITS-1:0]  o_exp,
    output logic [HANDLE_W-1:0]   o_handle,
    output logic                  o_le,
    output logic                  o_due,
    output logic                  o_hit
);
    import teq_pkg::*;

    logic                 r_valid;
    logic [TIME_BITS-1:0] r_exp;
    logic [HANDLE_W-1:0]  r_handle;

    logic [HANDLE_W+TGT_W-1:0] w_own_ext;
    logic [HANDLE_W+TGT_W-1:0] w_tgt_ext;
    logic                      w_match;

    assign w_own_ext = {{TGT_W{1'b0}}, r_handle};
    assign w_tgt_ext = {{HANDLE_W{1'b0}}, i_tgt};
    assign w_match   = r_valid && (w_own_ext == w_tgt_ext);

    // equal expiries stay ahead of a new entry
    assign o_le  = r_valid && (r_exp <= i_key);
    assign o_due = r_valid && (r_exp <= i_now);
    assign o_hit = i_hit_in || w_match;

    assign o_valid  = r_valid;
    assign o_exp    = r_exp;
    assign o_handle = r_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ins) begin
            if (!o_le) begin
                if (i_left_le) begin
                    r_valid  <= 1'b1;
                    r_exp    <= i_key;
                    r_handle <= i_new_handle;
                end else begin
                    r_valid  <= i_left_valid;
                    r_exp    <= i_left_exp;
                    r_handle <= i_left_handle;
                end
            end
        end else if (i_cmd.pop || (i_cmd.del && o_hit)) begin
            r_valid  <= i_right_valid;
            r_exp    <= i_right_exp;
            r_handle <= i_right_handle;
        end
    end

endmodule

// ===== sv/timeout_expiry_queue_core.sv =====
// Sorted timer queue on a chain of TABLE_DEPTH cells, cell 0 holding the earliest expiry and
// ties kept in arrival order. Each input word is add (expiry = now + offset, saturating at
// the largest TIME_BITS value, under the lowest free handle), delete by handle, or tick,
// which returns every due entry earliest first with tlast on the final one, or a single
// nothing-due word. Every result word carries the wait to the earliest pending expiry and an
// empty flag, both as they stand after the whole request. The request word is taken in idle, then
// every cell compares and shifts at once in the exec state, then the report or pop state loads
// each result word into the output register; no new word is taken until back in idle, and the
// output register stalls the chain when the downstream side holds tready low.
module timeout_expiry_queue_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // now_ms [31:0], offset_ms [63:32], target_handle [67:64], zero [71:68]
    input  logic [teq_pkg::IN_DATA_W-1:0]      i_s_tdata,
    // req_type [1:0]
    input  logic [teq_pkg::IN_USER_W-1:0]      i_s_tuser,
    // master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // result_handle [3:0], queue_empty [4], wait_ms [36:5], zero [39:37]
    output logic [teq_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    // status [2:0]
    output logic [teq_pkg::OUT_USER_W-1:0]     o_m_tuser,
    output logic                               o_m_tlast
);
    import teq_pkg::*;

    localparam int HW = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REPORT,
        S_POP
    } t_state;

    t_state r_state;

    // request word held while it is worked on
    logic [1:0]           r_req;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_off;
    logic [TGT_W-1:0]     r_tgt;

    // result of add, delete, an idle tick or a reserved request
    logic [2:0]           r_status;
    logic [HW-1:0]        r_handle;

    // state after a tick, captured before popping starts
    logic [TIME_BITS-1:0] r_sel_exp;
    logic                 r_final_empty;

    logic [TABLE_DEPTH-1:0] r_busy;

    // output register
    logic                 r_out_valid;
    logic [2:0]           r_out_status;
    logic [3:0]           r_out_handle;
    logic                 r_out_last;
    logic                 r_out_empty;
    logic [FIELD_W-1:0]   r_out_wait;

    // cell chain taps
    logic                 w_valid  [TABLE_DEPTH];
    logic [TIME_BITS-1:0] w_exp    [TABLE_DEPTH];
    logic [HW-1:0]        w_handle [TABLE_DEPTH];
    logic                 w_le     [TABLE_DEPTH];
    logic                 w_due    [TABLE_DEPTH];
    logic                 w_hit    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_valid_vec;
    logic [TABLE_DEPTH-1:0] w_due_vec;
    logic [TABLE_DEPTH-1:0] w_due_prev;

    t_cell_cmd            w_cmd;
    logic [TIME_BITS:0]   n_sum;
    logic [TIME_BITS-1:0] n_key;
    logic [HW-1:0]        n_free;
    logic [TIME_BITS-1:0] n_sel_exp;
    logic                 n_any_left;
    logic                 w_full;
    logic                 w_out_free;
    logic                 w_out_load;
    logic                 w_s_acc;

    logic [TIME_BITS+FIELD_W-1:0] w_now_ext;
    logic [TIME_BITS+FIELD_W-1:0] w_off_ext;
    logic [TIME_BITS-1:0]         n_head_wait;
    logic [TIME_BITS-1:0]         n_tick_wait;
    logic [TIME_BITS+FIELD_W-1:0] w_head_wait_ext;
    logic [TIME_BITS+FIELD_W-1:0] w_tick_wait_ext;
    logic [HW+3:0]                w_res_handle_ext;
    logic [HW+3:0]                w_head_handle_ext;
    logic [HW+TGT_W-1:0]          w_tgt_ext;

    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    // a result word goes into the output register this cycle
    assign w_out_load = w_out_free && ((r_state == S_REPORT) || (r_state == S_POP));
    assign o_s_tready = (r_state == S_IDLE);

    // time fields reduced to TIME_BITS
    assign w_now_ext = {{TIME_BITS{1'b0}}, i_s_tdata[FIELD_W-1:0]};
    assign w_off_ext = {{TIME_BITS{1'b0}}, i_s_tdata[2*FIELD_W-1:FIELD_W]};

    // saturating expiry for add
    assign n_sum = {1'b0, r_now} + {1'b0, r_off};
    assign n_key = n_sum[TIME_BITS] ? '1 : n_sum[TIME_BITS-1:0];

    // lowest free handle
    always_comb begin
        n_free = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                n_free = HW'(i);
            end
        end
    end

    // the tail cell holds an entry only when the table is full
    assign w_full = w_valid[TABLE_DEPTH-1];

    always_comb begin
        w_cmd     = '0;
        w_cmd.ins = (r_state == S_EXEC) && (r_req == REQ_ADD) && !w_full;
        w_cmd.del = (r_state == S_EXEC) && (r_req == REQ_DEL);
        w_cmd.pop = (r_state == S_POP) && w_out_free;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic                 w_lv;
            logic [TIME_BITS-1:0] w_le_exp;
            logic [HW-1:0]        w_lh;
            logic                 w_lle;
            logic                 w_rv;
            logic [TIME_BITS-1:0] w_re;
            logic [HW-1:0]        w_rh;
            logic                 w_hin;

            if (g == 0) begin : g_head
                assign w_lv     = 1'b0;
                assign w_le_exp = '0;
                assign w_lh     = '0;
                assign w_lle    = 1'b1;
                assign w_hin    = 1'b0;
            end else begin : g_body
                assign w_lv     = w_valid[g-1];
                assign w_le_exp = w_exp[g-1];
                assign w_lh     = w_handle[g-1];
                assign w_lle    = w_le[g-1];
                assign w_hin    = w_hit[g-1];
            end

            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign w_rv = 1'b0;
                assign w_re = '0;
                assign w_rh = '0;
            end else begin : g_inner
                assign w_rv = w_valid[g+1];
                assign w_re = w_exp[g+1];
                assign w_rh = w_handle[g+1];
            end

            teq_cell #(
                .TIME_BITS (TIME_BITS),
                .HANDLE_W  (HW)
            ) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_cmd          (w_cmd),
                .i_key          (n_key),
                .i_now          (r_now),
                .i_tgt          (r_tgt),
                .i_new_handle   (n_free),
                .i_left_valid   (w_lv),
                .i_left_exp     (w_le_exp),
                .i_left_handle  (w_lh),
                .i_left_le      (w_lle),
                .i_right_valid  (w_rv),
                .i_right_exp    (w_re),
                .i_right_handle (w_rh),
                .i_hit_in       (w_hin),
                .o_valid        (w_valid[g]),
                .o_exp          (w_exp[g]),
                .o_handle       (w_handle[g]),
                .o_le           (w_le[g]),
                .o_due          (w_due[g]),
                .o_hit          (w_hit[g])
            );

            assign w_valid_vec[g] = w_valid[g];
            assign w_due_vec[g]   = w_due[g];
        end
    endgenerate

    // first pending entry that is not yet due becomes the head after a tick
    assign w_due_prev = {w_due_vec[TABLE_DEPTH-2:0], 1'b1};

    always_comb begin
        n_sel_exp  = '0;
        n_any_left = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_valid_vec[i] && !w_due_vec[i] && w_due_prev[i]) begin
                n_sel_exp  = n_sel_exp | w_exp[i];
                n_any_left = 1'b1;
            end
        end
    end

    // wait from the current head, clamped at zero
    assign n_head_wait = (w_valid[0] && (w_exp[0] > r_now)) ? (w_exp[0] - r_now) : '0;
    assign n_tick_wait = r_final_empty ? '0 : (r_sel_exp - r_now);
    assign w_head_wait_ext = {{FIELD_W{1'b0}}, n_head_wait};
    assign w_tick_wait_ext = {{FIELD_W{1'b0}}, n_tick_wait};

    assign w_res_handle_ext  = {4'b0, r_handle};
    assign w_head_handle_ext = {4'b0, w_handle[0]};
    assign w_tgt_ext         = {{HW{1'b0}}, r_tgt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_req   <= i_s_tuser;
                        r_now   <= w_now_ext[TIME_BITS-1:0];
                        r_off   <= w_off_ext[TIME_BITS-1:0];
                        r_tgt   <= i_s_tdata[2*FIELD_W+TGT_W-1:2*FIELD_W];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_req)
                        REQ_ADD: begin
                            r_state <= S_REPORT;
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_handle <= '0;
                            end else begin
                                r_status       <= ST_ADDED;
                                r_handle       <= n_free;
                                r_busy[n_free] <= 1'b1;
                            end
                        end
                        REQ_DEL: begin
                            r_state <= S_REPORT;
                            // a hit implies the handle fits the table
                            if (w_hit[TABLE_DEPTH-1]) begin
                                r_status <= ST_DELETED;
                                r_handle <= w_tgt_ext[HW-1:0];
                                r_busy[w_tgt_ext[HW-1:0]] <= 1'b0;
                            end else begin
                                r_status <= ST_NOT_FOUND;
                                r_handle <= '0;
                            end
                        end
                        REQ_TICK: begin
                            r_status      <= ST_NONE_DUE;
                            r_handle      <= '0;
                            r_sel_exp     <= n_sel_exp;
                            r_final_empty <= !n_any_left;
                            if (w_due[0]) begin
                                r_state <= S_POP;
                            end else begin
                                r_state <= S_REPORT;
                            end
                        end
                        default: begin
                            r_state  <= S_REPORT;
                            r_status <= ST_NONE_DUE;
                            r_handle <= '0;
                        end
                    endcase
                end
                S_REPORT: begin
                    if (w_out_free) begin
                        r_out_status <= r_status;
                        r_out_handle <= w_res_handle_ext[3:0];
                        r_out_last   <= 1'b1;
                        r_out_empty  <= !w_valid[0];
                        r_out_wait   <= w_head_wait_ext[FIELD_W-1:0];
                        r_state      <= S_IDLE;
                    end
                end
                S_POP: begin
                    if (w_out_free) begin
                        r_out_status <= ST_EXPIRED;
                        r_out_handle <= w_head_handle_ext[3:0];
                        r_out_last   <= !w_due[1];
                        r_out_empty  <= r_final_empty;
                        r_out_wait   <= w_tick_wait_ext[FIELD_W-1:0];
                        r_busy[w_handle[0]] <= 1'b0;
                        if (!w_due[1]) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {3'b0, r_out_wait, r_out_empty, r_out_handle};

`ifndef NO_ASSERTIONS
    // as many handles are busy as cells are occupied
    a_busy_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_busy) == $countones(w_valid_vec))
        else $error("busy handles and occupied cells disagree");

    // occupied cells form an unbroken run from the head
    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid_vec >> 1) & ~w_valid_vec) == '0)
        else $error("gap in the cell chain");

    // popping only ever removes a due head
    a_pop_head_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> w_due[0])
        else $error("pop state with no due head");

    // a result word is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_handle)))
        else $error("pending result overwritten");
`endif

endmodule

// ===== test/timer_queue_checker.sv =====
`timescale 1ns / 100ps

module timer_queue_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // now_ms [31:0], offset_ms [63:32], target_handle [67:64], zero [71:68]
    input  logic [teq_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // req_type [1:0]
    input  logic [teq_pkg::IN_USER_W-1:0]  i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // result_handle [3:0], queue_empty [4], wait_ms [36:5], zero [39:37]
    input  logic [teq_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // status [2:0]
    input  logic [teq_pkg::OUT_USER_W-1:0] i_m_tuser,
    input  logic                           i_m_tlast,
    output int                             o_open_replies,
    output int                             o_fail_count
);
    import teq_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  handle;
        logic        last;
        logic        empty;
        logic [31:0] wait_ms;
    } t_reply;

    t_reply      reply_q[$];
    int          live_count;
    logic [31:0] slot_time [SLOTS];
    logic [3:0]  slot_id   [SLOTS];
    logic [SLOTS-1:0] id_busy;
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endtask

    // applies one request to the shadow queue and queues the words it should produce
    task automatic serve_request(input logic [1:0] kind, input logic [31:0] now,
                                 input logic [31:0] off, input logic [3:0] tgt);
        logic [2:0]  st [SLOTS];
        logic [3:0]  hd [SLOTS];
        logic [32:0] sum;
        logic [31:0] due_at;
        logic [31:0] wait_v;
        int          n;
        int          k;
        int          pos;
        int          idx;
        t_reply      r;
        n     = 1;
        st[0] = ST_NONE_DUE;
        hd[0] = '0;
        case (kind)
            REQ_ADD: begin
                sum    = {1'b0, now} + {1'b0, off};
                due_at = sum[32] ? '1 : sum[31:0];
                idx = 0;
                while (idx < SLOTS && id_busy[idx]) idx++;
                if (live_count >= SLOTS || idx >= SLOTS) begin
                    st[0] = ST_FULL;
                end else begin
                    // ties go behind existing entries
                    pos = 0;
                    while (pos < live_count && slot_time[pos] <= due_at) pos++;
                    for (k = live_count; k > pos; k--) begin
                        slot_time[k] = slot_time[k-1];
                        slot_id[k]   = slot_id[k-1];
                    end
                    slot_time[pos] = due_at;
                    slot_id[pos]   = idx[3:0];
                    id_busy[idx]   = 1'b1;
                    live_count++;
                    st[0] = ST_ADDED;
                    hd[0] = idx[3:0];
                end
            end
            REQ_DEL: begin
                pos = 0;
                while (pos < live_count && slot_id[pos] != tgt) pos++;
                if (pos < live_count) begin
                    for (k = pos; k + 1 < live_count; k++) begin
                        slot_time[k] = slot_time[k+1];
                        slot_id[k]   = slot_id[k+1];
                    end
                    id_busy[tgt] = 1'b0;
                    live_count--;
                    st[0] = ST_DELETED;
                    hd[0] = tgt;
                end else begin
                    st[0] = ST_NOT_FOUND;
                end
            end
            REQ_TICK: begin
                k = 0;
                while (k < live_count && slot_time[k] <= now) begin
                    st[k] = ST_EXPIRED;
                    hd[k] = slot_id[k];
                    id_busy[slot_id[k]] = 1'b0;
                    k++;
                end
                if (k > 0) begin
                    for (idx = k; idx < live_count; idx++) begin
                        slot_time[idx-k] = slot_time[idx];
                        slot_id[idx-k]   = slot_id[idx];
                    end
                    live_count -= k;
                    n = k;
                end
            end
            default: ;
        endcase
        wait_v = (live_count != 0 && slot_time[0] > now) ? slot_time[0] - now : '0;
        for (idx = 0; idx < n; idx++) begin
            r.status  = st[idx];
            r.handle  = hd[idx];
            r.last    = (idx == n - 1);
            r.empty   = (live_count == 0);
            r.wait_ms = wait_v;
            reply_q.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            live_count = 0;
            id_busy    = '0;
            reply_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    $error("unexpected result word: status %0d handle %0d",
                           i_m_tuser, i_m_tdata[3:0]);
                    fails++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_m_tuser));
                    check_field("result_handle", 32'(want.handle), 32'(i_m_tdata[3:0]));
                    check_field("last", 32'(want.last), 32'(i_m_tlast));
                    check_field("queue_empty", 32'(want.empty), 32'(i_m_tdata[4]));
                    check_field("wait_ms", want.wait_ms, i_m_tdata[36:5]);
                end
            end
            if (i_s_tvalid && i_s_tready)
                serve_request(i_s_tuser, i_s_tdata[31:0], i_s_tdata[63:32], i_s_tdata[67:64]);
        end
        o_open_replies <= reply_q.size();
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import teq_pkg::*;

    // req_type 3 has no meaning; the queue answers it with one nothing-due word
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    // hard stop for the whole run, well above the slowest legal run
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_REQS  = 80;
    // receiver goes quiet once, long enough for the chain and the input to back up
    localparam int          HOLD_AT_WORD = 60;
    localparam int          HOLD_CYCLES  = 400;
    // settle time, long enough for a tick that empties a full table
    localparam int          SETTLE_CYCLES = 30;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = '0;
    logic                  m_tready = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  m_tlast;

    int          open_replies;
    int          fail_count;
    int unsigned cycle_cnt  = 0;
    int          sent_count = 0;
    logic [31:0] clock_ms;

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    timeout_expiry_queue_core u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    timer_queue_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_m_tlast      (m_tlast),
        .o_open_replies (open_replies),
        .o_fail_count   (fail_count)
    );

    // hard stop in case the block hangs or loses words
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // offers one request word and returns at the edge where it is taken;
    // tvalid stays high on return so back-to-back words need no second drive
    task automatic offer_request(input logic [1:0] kind, input logic [31:0] now,
                                 input logic [31:0] off, input logic [3:0] tgt);
        int gap;
        // every other run of sixteen words goes without gaps
        gap = sent_count[4] ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, tgt, off, now};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // sender stands back until every predicted word has come out
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (open_replies != 0);
    endtask

    // stimulus and verdict
    initial begin
        int          i;
        int          roll;
        logic [1:0]  kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty queue answers
        offer_request(REQ_TICK, 32'd0, 32'd0, 4'd0);
        offer_request(REQ_RESERVED, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 4'hA);
        offer_request(REQ_DEL, 32'd5, 32'd0, 4'hF);
        // due at once, saturating sum, exact maximum, then two equal expiries
        offer_request(REQ_ADD, 32'd100, 32'd0, 4'd0);
        offer_request(REQ_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 4'd0);
        offer_request(REQ_ADD, 32'd0, 32'hFFFF_FFFF, 4'd0);
        offer_request(REQ_ADD, 32'd50, 32'd50, 4'd0);
        offer_request(REQ_ADD, 32'd50, 32'd50, 4'd0);
        // fill every slot, then one add too many
        for (i = 0; i < 11; i++)
            offer_request(REQ_ADD, 32'd10, 32'($urandom_range(0, 300)), 4'd0);
        offer_request(REQ_ADD, 32'd20, 32'd5, 4'd0);
        // delete a live handle, then the same one again
        offer_request(REQ_DEL, 32'd20, 32'd0, 4'd3);
        offer_request(REQ_DEL, 32'd20, 32'd0, 4'd3);
        // partial expiry, then everything including the saturated entries
        offer_request(REQ_TICK, 32'd100, 32'd0, 4'd0);
        offer_request(REQ_TICK, 32'hFFFF_FFFF, 32'd0, 4'd0);
        drain_replies();

        // random: a steadily advancing clock with short offsets, so entries
        // pile up and fall due; one request in ten carries wild values
        clock_ms = 32'd1000;
        for (i = 0; i < RANDOM_REQS; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                kind = REQ_ADD;
            else if (roll < 65)
                kind = REQ_DEL;
            else if (roll < 95)
                kind = REQ_TICK;
            else
                kind = REQ_RESERVED;
            clock_ms += $urandom_range(0, 30);
            if ($urandom_range(0, 9) == 0)
                offer_request(kind, $urandom, $urandom, 4'($urandom_range(0, 15)));
            else
                offer_request(kind, clock_ms, 32'($urandom_range(0, 150)),
                              4'($urandom_range(0, 15)));
        end
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // receiver: random stalls per word, calm stretches, and one long hold-off
    // while the sender keeps offering
    initial begin
        int gap;
        int words_taken;
        bit held;
        words_taken = 0;
        held        = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!held && words_taken >= HOLD_AT_WORD) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = words_taken[5] ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            words_taken++;
        end
    end

endmodule
